### src/multi_queue_linked_list_manager_unit_defines.svh
// Assertion macros shared by the multi-queue linked list manager.
`ifndef MULTI_QUEUE_LINKED_LIST_MANAGER_UNIT_DEFINES_SVH
`define MULTI_QUEUE_LINKED_LIST_MANAGER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the cycle after the antecedent.
`define MQLLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define MQLLM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/mqllm_pkg.sv
// Shared types and constants of the multi-queue linked list manager.
package mqllm_pkg;

  localparam int OPCODE_W = 2;
  localparam int QIDX_W   = 3;
  localparam int NIDX_W   = 6;
  localparam int STATUS_W = 2;
  localparam int QLEN_W   = 7;

  localparam logic [OPCODE_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REM = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISUSE = 2'd2;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_WR    = 6'b001000,
    S_LINK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic req_load;
    logic rd_head;
    logic wr_main;
    logic wr_link;
    logic clr_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic op_ok;
    logic op_enq;
    logic op_deq;
    logic out_free;
  } stat_t;

endpackage

### src/mqllm_dp.sv
// Datapath: request registers, queue and node memories, and result register.
module mqllm_dp
  import mqllm_pkg::*;
#(
  parameter int NUM_QUEUES = 8,
  parameter int NUM_NODES  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [QIDX_W-1:0]   queue_index,
  input  logic [NIDX_W-1:0]   node_index,
  input  cmd_t                cmd,
  output stat_t               stat,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [STATUS_W-1:0] status,
  output logic [NIDX_W-1:0]   node_out,
  output logic [QLEN_W-1:0]   queue_length
);

  localparam int NAW   = $clog2(NUM_NODES);
  localparam int PW    = $clog2(NUM_NODES + 1);
  localparam int QAW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int OW    = $clog2(NUM_QUEUES + 1);
  localparam int CLR_N = (NUM_NODES > NUM_QUEUES) ? NUM_NODES : NUM_QUEUES;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [PW-1:0] NODE_NONE  = PW'(NUM_NODES);
  localparam logic [OW-1:0] OWNER_NONE = OW'(NUM_QUEUES);

  logic [OPCODE_W-1:0] op_r;
  logic [QIDX_W-1:0]   q_r;
  logic [NIDX_W-1:0]   n_r;

  logic [PW-1:0] head_mem  [NUM_QUEUES];
  logic [PW-1:0] tail_mem  [NUM_QUEUES];
  logic [PW-1:0] len_mem   [NUM_QUEUES];
  logic [OW-1:0] owner_mem [NUM_NODES];
  logic [PW-1:0] next_mem  [NUM_NODES];
  logic [PW-1:0] prev_mem  [NUM_NODES];

  logic [PW-1:0] head_rd, tail_rd, len_rd, next_rd, prev_rd;
  logic [OW-1:0] owner_rd;

  logic [CW-1:0] clr_cnt;

  logic          q_we, own_we, nxt_we, prv_we;
  logic [QAW-1:0] q_wa;
  logic [NAW-1:0] own_wa, nxt_wa, prv_wa, nxt_ra;
  logic [PW-1:0]  head_wd, tail_wd, len_wd, nxt_wd, prv_wd;
  logic [OW-1:0]  own_wd;

  logic           q_valid, n_valid, is_enq, is_deq, is_rem;
  logic           enq_ok, deq_ok, rem_ok, op_ok, head_none, tail_none;
  logic [QAW-1:0] qa_r;
  logic [NAW-1:0] na_r;
  logic [PW-1:0]  len_new;
  logic [STATUS_W-1:0] status_new;
  logic [NIDX_W-1:0]   node_new;

  // Request registers.
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      op_r <= opcode;
      q_r  <= queue_index;
      n_r  <= node_index;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Decode of the held request against the state read for it.
  always_comb begin
    q_valid   = 32'(q_r) < NUM_QUEUES;
    n_valid   = 32'(n_r) < NUM_NODES;
    qa_r      = QAW'(q_r);
    na_r      = NAW'(n_r);
    is_enq    = op_r == OP_ENQ;
    is_deq    = op_r == OP_DEQ;
    is_rem    = op_r == OP_REM;
    head_none = head_rd == NODE_NONE;
    tail_none = tail_rd == NODE_NONE;
    deq_ok    = q_valid && is_deq && (len_rd != '0) && !head_none;
    enq_ok    = q_valid && is_enq && n_valid && (owner_rd == OWNER_NONE);
    rem_ok    = q_valid && is_rem && n_valid && (owner_rd == OW'(q_r));
    op_ok     = enq_ok || deq_ok || rem_ok;

    priority if (!q_valid) begin
      status_new = ST_MISUSE;
    end else if (is_deq && !deq_ok) begin
      status_new = ST_EMPTY;
    end else if (!op_ok) begin
      status_new = ST_MISUSE;
    end else begin
      status_new = ST_OK;
    end

    if (!op_ok) begin
      node_new = '0;
    end else if (is_deq) begin
      node_new = NIDX_W'(head_rd);
    end else begin
      node_new = n_r;
    end

    priority if (!q_valid || (is_deq && !deq_ok)) begin
      len_new = '0;
    end else if (enq_ok) begin
      len_new = len_rd + 1'b1;
    end else if (deq_ok || (rem_ok && len_rd != '0)) begin
      len_new = len_rd - 1'b1;
    end else begin
      len_new = len_rd;
    end
  end

  // Write ports of the memories.
  always_comb begin
    q_we    = 1'b0;
    q_wa    = qa_r;
    head_wd = head_rd;
    tail_wd = tail_rd;
    len_wd  = len_new;
    own_we  = 1'b0;
    own_wa  = na_r;
    own_wd  = OWNER_NONE;
    nxt_we  = 1'b0;
    nxt_wa  = na_r;
    nxt_wd  = NODE_NONE;
    prv_we  = 1'b0;
    prv_wa  = na_r;
    prv_wd  = NODE_NONE;
    if (cmd.clr_step) begin
      q_we    = 32'(clr_cnt) < NUM_QUEUES;
      q_wa    = QAW'(clr_cnt);
      head_wd = NODE_NONE;
      tail_wd = NODE_NONE;
      len_wd  = '0;
      own_we  = 32'(clr_cnt) < NUM_NODES;
      own_wa  = NAW'(clr_cnt);
    end else if (cmd.wr_main) begin
      q_we   = 1'b1;
      own_we = 1'b1;
      if (is_enq) begin
        own_wd  = OW'(q_r);
        nxt_we  = 1'b1;
        prv_we  = 1'b1;
        prv_wd  = tail_rd;
        head_wd = tail_none ? PW'(n_r) : head_rd;
        tail_wd = PW'(n_r);
      end else if (is_deq) begin
        own_wa  = NAW'(head_rd);
        prv_we  = next_rd != NODE_NONE;
        prv_wa  = NAW'(next_rd);
        head_wd = next_rd;
        tail_wd = (next_rd == NODE_NONE) ? NODE_NONE : tail_rd;
      end else begin
        nxt_we  = prev_rd != NODE_NONE;
        nxt_wa  = NAW'(prev_rd);
        nxt_wd  = next_rd;
        prv_we  = next_rd != NODE_NONE;
        prv_wa  = NAW'(next_rd);
        prv_wd  = prev_rd;
        head_wd = (prev_rd == NODE_NONE) ? next_rd : head_rd;
        tail_wd = (next_rd == NODE_NONE) ? prev_rd : tail_rd;
      end
    end else if (cmd.wr_link) begin
      nxt_we = !tail_none;
      nxt_wa = NAW'(tail_rd);
      nxt_wd = PW'(n_r);
    end
  end

  assign nxt_ra = cmd.rd_head ? NAW'(head_rd) : NAW'(node_index);

  // Per-queue memories share one address.
  always_ff @(posedge clk) begin
    if (q_we) begin
      head_mem[q_wa] <= head_wd;
      tail_mem[q_wa] <= tail_wd;
      len_mem[q_wa]  <= len_wd;
    end
    if (cmd.req_load) begin
      head_rd <= head_mem[QAW'(queue_index)];
      tail_rd <= tail_mem[QAW'(queue_index)];
      len_rd  <= len_mem[QAW'(queue_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      owner_mem[own_wa] <= own_wd;
    end
    if (cmd.req_load) begin
      owner_rd <= owner_mem[NAW'(node_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    if (cmd.req_load || cmd.rd_head) begin
      next_rd <= next_mem[nxt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prev_mem[prv_wa] <= prv_wd;
    end
    if (cmd.req_load) begin
      prev_rd <= prev_mem[NAW'(node_index)];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= status_new;
      node_out     <= node_new;
      queue_length <= QLEN_W'(len_new);
    end
  end

  always_comb begin
    stat.clr_last = 32'(clr_cnt) == CLR_N - 1;
    stat.op_ok    = op_ok;
    stat.op_enq   = is_enq;
    stat.op_deq   = is_deq;
    stat.out_free = !result_valid || !result_stall;
  end

endmodule

### src/mqllm_ctrl.sv
// Controller: sequences the clearing pass and the read and write steps of a request.
module mqllm_ctrl
  import mqllm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  request_valid,
  output logic  request_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    request_stall = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        request_stall = 1'b0;
        if (request_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.op_ok) begin
          cmd.rd_head = stat.op_deq;
          state_next  = S_WR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WR: begin
        cmd.wr_main = 1'b1;
        state_next  = stat.op_enq ? S_LINK : S_DONE;
      end
      S_LINK: begin
        cmd.wr_link = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

### src/multi_queue_linked_list_manager_unit.sv
// Top level of the multi-queue linked list manager.
//
//   Channel   Handshake                       Payload
//   request   request_valid / request_stall   opcode, queue_index, node_index
//   result    result_valid / result_stall     status, node_out, queue_length
//
// An accepted request passes through decode, one write step and the load into the
// result register. An enqueue adds a second write step for the old tail's next
// link; a rejected request skips the writes.
// The next request is taken in the idle state after the load.
// After reset a clearing pass over the queue and node memories holds request_stall.
// A stalled result stays in its register; the next request is still accepted and
// waits in its last step until the result register frees up.
`include "multi_queue_linked_list_manager_unit_defines.svh"

module multi_queue_linked_list_manager_unit
  import mqllm_pkg::*;
#(
  parameter int NUM_QUEUES = 8,
  parameter int NUM_NODES  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  output logic                request_stall,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [QIDX_W-1:0]   queue_index,
  input  logic [NIDX_W-1:0]   node_index,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [STATUS_W-1:0] status,
  output logic [NIDX_W-1:0]   node_out,
  output logic [QLEN_W-1:0]   queue_length
);

  // The controller and datapath talk only through these two bundles.
  cmd_t  cmd;
  stat_t stat;

  mqllm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  // The datapath holds the per-queue head, tail and length memories and the
  // per-node owner, next and previous link memories.
  mqllm_dp #(
    .NUM_QUEUES (NUM_QUEUES),
    .NUM_NODES  (NUM_NODES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .opcode       (opcode),
    .queue_index  (queue_index),
    .node_index   (node_index),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .node_out     (node_out),
    .queue_length (queue_length)
  );

  // The block goes busy right after it takes a request.
  `MQLLM_ASSERT_NEXT(a_busy_after_accept, request_valid && !request_stall,
                     request_stall, "request accepted but block not busy next cycle")
  // A result is only produced at the end of a request, never from idle.
  `MQLLM_ASSERT_NEXT(a_no_result_from_idle, !request_stall && !result_valid,
                     !result_valid, "result appeared without a request in progress")
  // Failed operations report no node.
  `MQLLM_ASSERT_SAME(a_node_zero_on_error, result_valid && status != ST_OK,
                     node_out == '0, "nonzero node on failed request")
  // An empty dequeue reports a zero length.
  `MQLLM_ASSERT_SAME(a_empty_len_zero, result_valid && status == ST_EMPTY,
                     queue_length == '0, "empty dequeue with nonzero length")

endmodule
